FILE: rtl/framebuffer_rect_fill_defines.svh
// assertion macros shared by the rectangle fill engine
`ifndef FRAMEBUFFER_RECT_FILL_DEFINES_SVH
`define FRAMEBUFFER_RECT_FILL_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RFILL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfill check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RFILL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfill check failed");

`endif

FILE: rtl/rfill_pkg.sv
// shared constants, config type and helpers for the rectangle fill engine
package rfill_pkg;

    // pixel format codes
    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_8BPP  = 3'd1;
    localparam logic [2:0] FMT_16BPP = 3'd2;
    localparam logic [2:0] FMT_24BPP = 3'd3;
    localparam logic [2:0] FMT_32BPP = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_FRAME_BASE   = 2'd0;
    localparam logic [1:0] REG_ROW_STRIDE   = 2'd1;
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd2;

    // item kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    localparam logic [31:0] FRAME_BASE_RESET   = 32'd0;
    localparam logic [15:0] ROW_STRIDE_RESET   = 16'd960;
    localparam logic [2:0]  PIXEL_FORMAT_RESET = FMT_16BPP;

    localparam logic [31:0] ALPHA_OPAQUE = 32'hff00_0000;
    localparam logic [7:0]  BYTE_ONES    = 8'hff;

    typedef struct packed {
        logic [31:0] frame_base;
        logic [15:0] row_stride;
        logic [2:0]  pixel_format;
    } rfill_cfg_t;

    // width of one queued command, must match the layout in front and back
    function automatic int cmd_bits(input int coord_bits);
        return 3 * coord_bits + 87;
    endfunction

    function automatic logic [2:0] bytes_per_write(input logic [2:0] fmt);
        logic [2:0] bpw;
        unique case (fmt)
            FMT_1BPP:  bpw = 3'd1;
            FMT_8BPP:  bpw = 3'd1;
            FMT_16BPP: bpw = 3'd2;
            FMT_24BPP: bpw = 3'd3;
            FMT_32BPP: bpw = 3'd4;
            default:   bpw = 3'd1;
        endcase
        return bpw;
    endfunction

endpackage

FILE: rtl/rfill_front.sv
// front end: classifies items and precomputes rectangle setup for the back end
module rfill_front
    import rfill_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  rfill_cfg_t                          cfg,
    input  logic                                kind,
    input  logic [COORD_BITS-1:0]               rect_x,
    input  logic [COORD_BITS-1:0]               rect_y,
    input  logic [COORD_BITS-1:0]               rect_w,
    input  logic [COORD_BITS-1:0]               rect_h,
    input  logic [23:0]                         fill_color,
    output logic [cmd_bits(COORD_BITS)-1:0]     cmd_data
);

    typedef struct packed {
        logic                  kind;
        logic                  rect_ok;
        logic [2:0]            format;
        logic [31:0]           row_address;
        logic [COORD_BITS-1:0] rows;
        logic [COORD_BITS:0]   col_start;
        logic [COORD_BITS:0]   col_end;
        logic [31:0]           pixel_word;
        logic [7:0]            left_mask;
        logic [7:0]            right_mask;
    } rfill_cmd_t;

    rfill_cmd_t              cmd;
    logic [15+COORD_BITS:0]  row_offset;
    logic [COORD_BITS:0]     x_ext;
    logic [COORD_BITS:0]     w_ext;
    logic [COORD_BITS:0]     right_col;

    always_comb
    begin
        x_ext      = {1'b0, rect_x};
        w_ext      = {1'b0, rect_w};
        right_col  = x_ext + w_ext - 1'b1;
        row_offset = cfg.row_stride * rect_y;

        cmd.kind        = kind;
        cmd.rect_ok     = (rect_w != '0) && (rect_h != '0) && (cfg.pixel_format <= FMT_32BPP);
        cmd.format      = cfg.pixel_format;
        cmd.row_address = cfg.frame_base + 32'(row_offset);
        cmd.rows        = rect_h;

        if (cfg.pixel_format == FMT_1BPP)
        begin
            // byte columns, leftmost pixel in the msb
            cmd.col_start  = x_ext >> 3;
            cmd.col_end    = (right_col >> 3) + 1'b1;
            cmd.left_mask  = BYTE_ONES >> rect_x[2:0];
            cmd.right_mask = BYTE_ONES << (3'd7 - right_col[2:0]);
        end
        else
        begin
            cmd.col_start  = x_ext;
            cmd.col_end    = x_ext + w_ext;
            cmd.left_mask  = BYTE_ONES;
            cmd.right_mask = BYTE_ONES;
        end

        unique case (cfg.pixel_format)
            FMT_1BPP:  cmd.pixel_word = fill_color[0] ? 32'(BYTE_ONES) : 32'd0;
            FMT_8BPP:  cmd.pixel_word = {24'd0, fill_color[7:0]};
            FMT_16BPP: cmd.pixel_word = {16'd0, fill_color[15:0]};
            FMT_24BPP: cmd.pixel_word = {8'd0, fill_color};
            FMT_32BPP: cmd.pixel_word = {8'd0, fill_color} | ALPHA_OPAQUE;
            default:   cmd.pixel_word = 32'd0;
        endcase
    end

    assign cmd_data = cmd;

endmodule

FILE: rtl/rfill_queue.sv
// small register queue between the front and back ends
module rfill_queue
    import rfill_pkg::*;
#(
    parameter int WIDTH = 123,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

endmodule

FILE: rtl/rfill_back.sv
// back end: walks the rectangle and issues one memory write per advance while a fill is in progress
module rfill_back
    import rfill_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rfill_cfg_t                      cfg,
    input  logic [cmd_bits(COORD_BITS)-1:0] cmd_data,
    input  logic                            cmd_valid,
    output logic                            cmd_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [31:0]                     write_address,
    output logic [31:0]                     write_data,
    output logic [2:0]                      byte_count,
    output logic [7:0]                      bit_mask,
    output logic                            last_write
);

    typedef struct packed {
        logic                  kind;
        logic                  rect_ok;
        logic [2:0]            format;
        logic [31:0]           row_address;
        logic [COORD_BITS-1:0] rows;
        logic [COORD_BITS:0]   col_start;
        logic [COORD_BITS:0]   col_end;
        logic [31:0]           pixel_word;
        logic [7:0]            left_mask;
        logic [7:0]            right_mask;
    } rfill_cmd_t;

    rfill_cmd_t cmd;

    // walk state
    logic                  busy_reg, busy_next;
    logic [2:0]            format_reg, format_next;
    logic [31:0]           row_address_reg, row_address_next;
    logic [COORD_BITS-1:0] rows_left_reg, rows_left_next;
    logic [COORD_BITS:0]   col_pos_reg, col_pos_next;
    logic [COORD_BITS:0]   col_start_reg, col_start_next;
    logic [COORD_BITS:0]   col_end_reg, col_end_next;
    logic [31:0]           pixel_word_reg, pixel_word_next;
    logic [7:0]            left_mask_reg, left_mask_next;
    logic [7:0]            right_mask_reg, right_mask_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] address_reg, address_next;
    logic [31:0] data_reg, data_next;
    logic [2:0]  count_reg, count_next;
    logic [7:0]  mask_reg, mask_next;
    logic        last_reg, last_next;

    logic                  can_issue;
    logic                  issue;
    logic [COORD_BITS:0]   col_inc;
    logic                  row_done;
    logic                  last_col;
    logic [2:0]            bpw;
    logic [COORD_BITS+2:0] col_ext;
    logic [COORD_BITS+2:0] byte_offset;
    logic [7:0]            mask;

    assign cmd       = rfill_cmd_t'(cmd_data);
    assign can_issue = !out_valid_reg || !out_stall;
    assign cmd_pop   = cmd_valid && can_issue;
    assign issue     = cmd_pop && (cmd.kind == KIND_ADVANCE) && busy_reg;

    always_comb
    begin
        bpw      = bytes_per_write(format_reg);
        col_inc  = col_pos_reg + 1'b1;
        row_done = (col_inc == col_end_reg);
        last_col = row_done && (rows_left_reg == COORD_BITS'(1));
        col_ext  = {2'b00, col_pos_reg};

        // column times bytes per pixel, at most four
        unique case (bpw)
            3'd2:    byte_offset = col_ext << 1;
            3'd3:    byte_offset = col_ext + (col_ext << 1);
            3'd4:    byte_offset = col_ext << 2;
            default: byte_offset = col_ext;
        endcase

        mask = BYTE_ONES;
        if (format_reg == FMT_1BPP)
        begin
            if (col_pos_reg == col_start_reg)
            begin
                mask = mask & left_mask_reg;
            end
            if (row_done)
            begin
                mask = mask & right_mask_reg;
            end
        end
    end

    always_comb
    begin
        busy_next        = busy_reg;
        format_next      = format_reg;
        row_address_next = row_address_reg;
        rows_left_next   = rows_left_reg;
        col_pos_next     = col_pos_reg;
        col_start_next   = col_start_reg;
        col_end_next     = col_end_reg;
        pixel_word_next  = pixel_word_reg;
        left_mask_next   = left_mask_reg;
        right_mask_next  = right_mask_reg;

        out_valid_next = out_valid_reg && out_stall;
        address_next   = address_reg;
        data_next      = data_reg;
        count_next     = count_reg;
        mask_next      = mask_reg;
        last_next      = last_reg;

        if (cmd_pop && (cmd.kind == KIND_START))
        begin
            // a start replaces whatever is in progress
            busy_next        = cmd.rect_ok;
            format_next      = cmd.format;
            row_address_next = cmd.row_address;
            rows_left_next   = cmd.rows;
            col_pos_next     = cmd.col_start;
            col_start_next   = cmd.col_start;
            col_end_next     = cmd.col_end;
            pixel_word_next  = cmd.pixel_word;
            left_mask_next   = cmd.left_mask;
            right_mask_next  = cmd.right_mask;
        end
        else if (issue)
        begin
            out_valid_next = 1'b1;
            address_next   = row_address_reg + 32'(byte_offset);
            data_next      = pixel_word_reg;
            count_next     = bpw;
            mask_next      = mask;
            last_next      = last_col;

            if (last_col)
            begin
                busy_next      = 1'b0;
                rows_left_next = '0;
                col_pos_next   = col_inc;
            end
            else if (row_done)
            begin
                row_address_next = row_address_reg + {16'd0, cfg.row_stride};
                rows_left_next   = rows_left_reg - 1'b1;
                col_pos_next     = col_start_reg;
            end
            else
            begin
                col_pos_next = col_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        format_reg      <= format_next;
        row_address_reg <= row_address_next;
        rows_left_reg   <= rows_left_next;
        col_pos_reg     <= col_pos_next;
        col_start_reg   <= col_start_next;
        col_end_reg     <= col_end_next;
        pixel_word_reg  <= pixel_word_next;
        left_mask_reg   <= left_mask_next;
        right_mask_reg  <= right_mask_next;
        address_reg     <= address_next;
        data_reg        <= data_next;
        count_reg       <= count_next;
        mask_reg        <= mask_next;
        last_reg        <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign write_address = address_reg;
    assign write_data    = data_reg;
    assign byte_count    = count_reg;
    assign bit_mask      = mask_reg;
    assign last_write    = last_reg;

endmodule

FILE: rtl/framebuffer_rect_fill.sv
// top level of the solid rectangle fill engine
//
//  channel   signals                                          direction
//  input     in_valid, in_stall, kind, rect_x/y/w/h, fill_color  in (stall out)
//  output    out_valid, out_stall, write_address, write_data,
//            byte_count, bit_mask, last_write                  out (stall in)
//  config    cfg_write_en, cfg_index, cfg_data                 in
//
// one item per cycle sustained while out_stall is low; an advance is registered in the
// command queue, then its write is registered in the walker's output register
// reset is asynchronous: config and control registers go to their defaults and the engine is idle
// out_stall holds the output register; the QUEUE_DEPTH entry queue absorbs
// items meanwhile and in_stall is high only while that queue is full
module framebuffer_rect_fill
    import rfill_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [COORD_BITS-1:0] rect_x,
    input  logic [COORD_BITS-1:0] rect_y,
    input  logic [COORD_BITS-1:0] rect_w,
    input  logic [COORD_BITS-1:0] rect_h,
    input  logic [23:0]           fill_color,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           write_address,
    output logic [31:0]           write_data,
    output logic [2:0]            byte_count,
    output logic [7:0]            bit_mask,
    output logic                  last_write,

    input  logic                  cfg_write_en,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

`include "framebuffer_rect_fill_defines.svh"

    localparam int CMD_W = cmd_bits(COORD_BITS);

    rfill_cfg_t       cfg_reg, cfg_next;
    logic [CMD_W-1:0] front_cmd;
    logic [CMD_W-1:0] queue_cmd;
    logic             queue_full;
    logic             queue_empty;
    logic             queue_push;
    logic             queue_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_FRAME_BASE:   cfg_next.frame_base   = cfg_data;
                REG_ROW_STRIDE:   cfg_next.row_stride   = cfg_data[15:0];
                REG_PIXEL_FORMAT: cfg_next.pixel_format = cfg_data[2:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_base   <= FRAME_BASE_RESET;
            cfg_reg.row_stride   <= ROW_STRIDE_RESET;
            cfg_reg.pixel_format <= PIXEL_FORMAT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall   = queue_full;
    assign queue_push = in_valid && !queue_full;

    rfill_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .cfg        (cfg_reg),
        .kind       (kind),
        .rect_x     (rect_x),
        .rect_y     (rect_y),
        .rect_w     (rect_w),
        .rect_h     (rect_h),
        .fill_color (fill_color),
        .cmd_data   (front_cmd)
    );

    rfill_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_data (front_cmd),
        .pop       (queue_pop),
        .pop_data  (queue_cmd),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    rfill_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd_data      (queue_cmd),
        .cmd_valid     (!queue_empty),
        .cmd_pop       (queue_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_address (write_address),
        .write_data    (write_data),
        .byte_count    (byte_count),
        .bit_mask      (bit_mask),
        .last_write    (last_write)
    );

    // edge masks never cancel out, so a write always touches some bit
    `RFILL_ASSERT_NOW(a_mask_nonempty, out_valid, bit_mask != 8'h00)
    // partial masks only exist for single-byte writes
    `RFILL_ASSERT_NOW(a_wide_mask_full, out_valid && (byte_count != 3'd1), bit_mask == BYTE_ONES)
    // once the final write of a rectangle is taken the walker is idle
    `RFILL_ASSERT_NEXT(a_last_ends_fill, out_valid && !out_stall && last_write, !out_valid)

endmodule
